### hdl/mrbm_pkg.sv
// Package for the cartridge ROM/RAM bank mapper: field widths, bank word types,
// access and register codes, and the mode flag record.
// No dependencies; every other file of the block depends on it.
package mrbm_pkg;

    localparam int ROM_W   = 23;  // ROM byte address width
    localparam int RAM_W   = 17;  // RAM bank offset width
    localparam int ADDR_W  = 16;  // CPU bus address width
    localparam int DATA_W  = 8;   // CPU bus data width
    localparam int PADDR_W = 4;   // three 32-bit registers at 0x0, 0x4, 0x8
    localparam int PDATA_W = 32;

    typedef logic [ROM_W-1:0]  t_rom;
    typedef logic [RAM_W-1:0]  t_ram;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [DATA_W-1:0] t_data;

    // Access kind
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register window chosen by address[15:13]
    localparam logic [2:0] SEL_RAM_ENABLE = 3'd0;  // 0x0000-0x1FFF
    localparam logic [2:0] SEL_ROM_BANK   = 3'd1;  // 0x2000-0x3FFF
    localparam logic [2:0] SEL_RAM_BANK   = 3'd2;  // 0x4000-0x5FFF
    localparam logic [2:0] SEL_ROM_LOCK   = 3'd3;  // 0x6000-0x7FFF

    // Configuration register index (paddr[3:2])
    localparam logic [1:0] REG_TOP_BANK = 2'd0;
    localparam logic [1:0] REG_ROM_MASK = 2'd1;
    localparam logic [1:0] REG_RAM_PRES = 2'd2;

    localparam logic [3:0] RAM_ENABLE_KEY = 4'ha;

    typedef struct packed {
        logic mapped;
        logic lock;
        logic mux;
        logic mode;
        logic ramen;
    } t_flags;

    typedef struct packed {
        t_rom rom_address;
        logic rom_read_valid;
        t_ram ram_bank_offset;
        logic ram_enabled;
        logic is_mapped;
        logic bank_mode;
    } t_result;

endpackage

### hdl/mrbm_if.sv
// Valid/ready channel interfaces for the bank mapper: CPU access in, result out.
// Depends on mrbm_pkg for field widths.
interface mrbm_in_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [mrbm_pkg::ADDR_W-1:0] address;
    logic [mrbm_pkg::DATA_W-1:0] write_data;

    modport source (output valid, operation, address, write_data, input ready);
    modport sink   (input valid, operation, address, write_data, output ready);
endinterface

interface mrbm_out_if;
    logic                       valid;
    logic                       ready;
    logic [mrbm_pkg::ROM_W-1:0] rom_address;
    logic                       rom_read_valid;
    logic [mrbm_pkg::RAM_W-1:0] ram_bank_offset;
    logic                       ram_enabled;
    logic                       is_mapped;
    logic                       bank_mode;

    modport source (output valid, rom_address, rom_read_valid, ram_bank_offset,
                    ram_enabled, is_mapped, bank_mode, input ready);
    modport sink   (input valid, rom_address, rom_read_valid, ram_bank_offset,
                    ram_enabled, is_mapped, bank_mode, output ready);
endinterface

### hdl/multicart_rom_ram_bank_mapper.sv
// An accepted beat waits in the input register until its result is registered.
// Throughput: one access per cycle; set by the single decode/update stage between the
// input register and the result register, both of which advance while the sink takes beats.
// Reset (i_rst_n low, synchronous): both stages empty, bank selects and lock masks zero,
// upper window bank 0x4000, all mode flags clear, top bank 0, ROM mask 0x7FFFFF, no RAM.
module multicart_rom_ram_bank_mapper (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mrbm_pkg::PADDR_W-1:0]   paddr,
    input  logic [mrbm_pkg::PDATA_W-1:0]   pwdata,
    output logic [mrbm_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    // CPU access beats in, result beats out
    mrbm_in_if.sink                        i_in,
    mrbm_out_if.source                     o_out
);
    import mrbm_pkg::*;

    // ---------------- configuration registers ----------------
    t_rom r_top_bank;
    t_rom r_rom_mask;
    logic r_ram_present;

    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_bank    <= '0;
            r_rom_mask    <= '1;
            r_ram_present <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_TOP_BANK: r_top_bank    <= pwdata[ROM_W-1:0];
                REG_ROM_MASK: r_rom_mask    <= pwdata[ROM_W-1:0];
                REG_RAM_PRES: r_ram_present <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TOP_BANK: prdata = {{(PDATA_W-ROM_W){1'b0}}, r_top_bank};
            REG_ROM_MASK: prdata = {{(PDATA_W-ROM_W){1'b0}}, r_rom_mask};
            REG_RAM_PRES: prdata = {{(PDATA_W-1){1'b0}}, r_ram_present};
            default:      prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // Stage 1 holds the accepted beat; it is decoded and applied to the mapper
    // state when the result register can take the outcome.
    logic  r_s1_valid;
    logic  r_s1_op;
    t_addr r_s1_addr;
    t_data r_s1_data;
    logic  r_out_valid;
    t_result r_res;

    logic out_free;   // result register empty or being emptied this cycle
    logic s1_go;      // stage 1 beat is processed this cycle
    logic in_fire;

    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_go      = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;
    assign in_fire    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) r_s1_valid  <= i_in.valid;
            if (out_free)   r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op   <= i_in.operation;
            r_s1_addr <= i_in.address;
            r_s1_data <= i_in.write_data;
        end
    end

    // ---------------- mapper state ----------------
    t_rom   r_rom_sel;      // ROM bank select
    t_rom   r_upper_bank;   // bank seen by the upper ROM window
    t_ram   r_ram_sel;      // RAM bank select
    t_rom   r_rom_lock;     // ROM lock mask (bits frozen after mapping)
    t_ram   r_ram_lock;     // RAM lock mask
    t_ram   r_ram_out;      // RAM bank offset presented to the bus
    t_flags r_flags;

    t_rom   n_rom_sel;
    t_rom   n_upper_bank;
    t_ram   n_ram_sel;
    t_rom   n_rom_lock;
    t_ram   n_ram_lock;
    t_ram   n_ram_out;
    t_flags n_flags;
    t_result n_res;

    // In multiplex mode ROM select bits 19:18 stand in for RAM bank bits 14:13.
    function automatic t_ram mux_ram_bank(input t_ram ram_sel, input t_rom rom_sel,
                                          input logic mux);
        if (mux)
            return {ram_sel[16:15], rom_sel[19:18], 13'd0};
        return ram_sel;
    endfunction

    always_comb begin
        logic [6:0] lo_bank;
        logic [4:0] hi_bank;
        t_rom       nb_rom;
        t_ram       nb_ram;
        t_rom       rd_bank;

        n_rom_sel    = r_rom_sel;
        n_upper_bank = r_upper_bank;
        n_ram_sel    = r_ram_sel;
        n_rom_lock   = r_rom_lock;
        n_ram_lock   = r_ram_lock;
        n_ram_out    = r_ram_out;
        n_flags      = r_flags;
        lo_bank      = '0;
        hi_bank      = '0;
        nb_rom       = '0;
        nb_ram       = '0;
        rd_bank      = '0;
        n_res.rom_address    = '0;
        n_res.rom_read_valid = 1'b0;

        if (r_s1_op == OP_WRITE) begin
            unique case (r_s1_addr[15:13])
                SEL_RAM_ENABLE: begin
                    if (!r_flags.mapped) begin
                        n_ram_lock = {1'b1, r_s1_data[5:4], 14'd0};
                        if (r_s1_data[6]) n_flags.mapped = 1'b1;
                    end
                    if (r_ram_present) n_flags.ramen = (r_s1_data[3:0] == RAM_ENABLE_KEY);
                end
                SEL_ROM_BANK: begin
                    if (!r_flags.mapped) begin
                        // bank zero in the low five bits reads as bank one
                        lo_bank    = r_s1_data[6:0];
                        lo_bank[0] = lo_bank[0] | (r_s1_data[4:0] == 5'd0);
                        n_rom_sel  = {r_rom_sel[22:21], lo_bank, 14'd0};
                    end else begin
                        hi_bank   = (r_s1_data[4:0] == 5'd0) ? 5'd1 : r_s1_data[4:0];
                        nb_rom    = {4'd0, hi_bank, 14'd0};
                        n_rom_sel = (r_rom_sel & r_rom_lock) | (nb_rom & ~r_rom_lock);
                    end
                    n_upper_bank = n_rom_sel;
                end
                SEL_RAM_BANK: begin
                    if (!r_flags.mapped) begin
                        n_ram_sel    = {r_s1_data[3:0], 13'd0};
                        n_flags.lock = r_s1_data[6];
                    end else begin
                        nb_ram    = {2'd0, r_s1_data[1:0], 13'd0};
                        n_ram_sel = (r_ram_sel & r_ram_lock) | (nb_ram & ~r_ram_lock);
                    end
                    if (r_flags.mux)
                        nb_rom = {1'b0, r_rom_sel[21:20], n_ram_sel[14:13], r_rom_sel[17:13],
                                  13'd0};
                    else
                        nb_rom = r_rom_sel;
                    n_upper_bank = nb_rom & r_rom_mask;
                    if (r_ram_present)
                        n_ram_out = mux_ram_bank(n_ram_sel, r_rom_sel, r_flags.mux);
                end
                SEL_ROM_LOCK: begin
                    if (!r_flags.mapped) begin
                        n_rom_lock  = {3'b111, r_s1_data[5:2], 16'd0};
                        n_flags.mux = r_s1_data[6];
                    end
                    if (!r_flags.lock) n_flags.mode = r_s1_data[0];
                    if (r_ram_present)
                        n_ram_out = mux_ram_bank(r_ram_sel, r_rom_sel, n_flags.mux);
                end
                default: ;
            endcase
        end else if (!r_s1_addr[15]) begin
            // set-up mode reads the top bank; mapped reads follow the selects
            if (!r_s1_addr[14])
                rd_bank = r_flags.mapped ? (r_upper_bank & r_rom_lock) : r_top_bank;
            else
                rd_bank = r_flags.mapped ? r_upper_bank : (r_top_bank | (ROM_W)'(15'h4000));
            n_res.rom_address    = (rd_bank | {{(ROM_W-14){1'b0}}, r_s1_addr[13:0]})
                                   & r_rom_mask;
            n_res.rom_read_valid = 1'b1;
        end

        n_res.ram_bank_offset = n_ram_out;
        n_res.ram_enabled     = n_flags.ramen && r_ram_present;
        n_res.is_mapped       = n_flags.mapped;
        n_res.bank_mode       = n_flags.mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_sel    <= '0;
            r_upper_bank <= (ROM_W)'(15'h4000);
            r_ram_sel    <= '0;
            r_rom_lock   <= '0;
            r_ram_lock   <= '0;
            r_ram_out    <= '0;
            r_flags      <= '0;
        end else if (s1_go) begin
            r_rom_sel    <= n_rom_sel;
            r_upper_bank <= n_upper_bank;
            r_ram_sel    <= n_ram_sel;
            r_rom_lock   <= n_rom_lock;
            r_ram_lock   <= n_ram_lock;
            r_ram_out    <= n_ram_out;
            r_flags      <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) r_res <= n_res;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.rom_address     = r_res.rom_address;
    assign o_out.rom_read_valid  = r_res.rom_read_valid;
    assign o_out.ram_bank_offset = r_res.ram_bank_offset;
    assign o_out.ram_enabled     = r_res.ram_enabled;
    assign o_out.is_mapped       = r_res.is_mapped;
    assign o_out.bank_mode       = r_res.bank_mode;

`ifndef NO_ASSERTIONS
    // leaving set-up mode is one-way
    a_mapped_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.mapped |=> r_flags.mapped)
        else $error("mapped flag cleared");

    // a held stage 1 beat is not dropped while the result register is blocked
    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_free |=> r_s1_valid)
        else $error("stage 1 beat lost under stall");

    // no translated address leaves without a valid ROM read
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.rom_read_valid |-> r_res.rom_address == '0)
        else $error("rom_address set on a non-read beat");

    // RAM window reported enabled only with RAM fitted
    a_ramen_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.ram_enabled |-> r_ram_present)
        else $error("ram_enabled without RAM fitted");
`endif

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for multicart_rom_ram_bank_mapper: CPU access beats
// against a bank-state predictor. Depends on hdl/mrbm_pkg.sv and hdl/mrbm_if.sv.
module testbench;
    import mrbm_pkg::*;

    logic i_clk;
    logic i_rst_n;

    // APB config port
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    mrbm_in_if  in_if();
    mrbm_out_if out_if();

    multicart_rom_ram_bank_mapper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    localparam t_rom TOP_BANK_MAX = 23'h7f8000;  // highest legal top bank offset
    localparam t_rom ROM_MASK_ALL = 23'h7fffff;

    // Mapper model state: config copy plus bank/lock registers and flags
    t_rom        cfg_top_bank;
    t_rom        cfg_rom_mask;
    logic        cfg_ram_fitted;
    t_rom        rom_sel;
    t_rom        upper_bank;
    t_ram        ram_sel;
    t_ram        ram_out;
    logic [23:0] rom_lock;
    logic [17:0] ram_lock;
    t_flags      flags;

    t_result bank_results_q[$];  // predicted result beats, oldest first
    int      error_count;
    bit      steady_flow;        // set: neither side idles

    always #5 i_clk = ~i_clk;

    // Generous limit: worst case is every beat taking the longest gap on both sides
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // RAM bank as driven out: with multiplex on, ROM select bits 18..19 feed RAM bits 13..14
    function automatic t_ram muxed_ram_bank();
        logic [31:0] w;
        if (flags.mux)
            w = (({9'b0, rom_sel} >> 5) & 32'h6000) | ({15'b0, ram_sel} & 32'h18000);
        else
            w = {15'b0, ram_sel};
        return w[16:0];
    endfunction

    // Register write by window; before mapping set-up is free, after it locks apply
    function automatic void bus_write(t_addr addr, t_data d);
        logic [31:0] nb;
        logic        was_mapped;
        was_mapped = flags.mapped;
        case (addr[15:13])
            SEL_RAM_ENABLE: begin
                if (!was_mapped) begin
                    ram_lock = {2'b11, d[5:4], 14'b0};
                    if (d[6])
                        flags.mapped = 1'b1;
                end
                if (cfg_ram_fitted)
                    flags.ramen = (d[3:0] == RAM_ENABLE_KEY);
            end
            SEL_ROM_BANK: begin
                if (!was_mapped) begin
                    nb = ({24'b0, d} & 32'h7f) << 14;
                    if (d[4:0] == 5'd0)
                        nb = nb | 32'h4000;
                    nb = ({9'b0, rom_sel} & 32'h600000) | (nb & 32'h1fc000);
                end else begin
                    nb = ({24'b0, d} & 32'h1f) << 14;
                    if (nb == 32'h0)
                        nb = 32'h4000;  // bank zero maps to bank one
                    nb = ({9'b0, rom_sel} & {8'b0, rom_lock}) | (nb & ~{8'b0, rom_lock});
                end
                rom_sel    = nb[22:0];
                upper_bank = rom_sel;
            end
            SEL_RAM_BANK: begin
                if (!was_mapped) begin
                    ram_sel    = {d[3:0], 13'b0};
                    flags.lock = d[6];
                end else begin
                    nb      = ({24'b0, d} & 32'h3) << 13;
                    nb      = ({15'b0, ram_sel} & {14'b0, ram_lock}) | (nb & ~{14'b0, ram_lock});
                    ram_sel = nb[16:0];
                end
                // multiplex: RAM select bits 13..14 replace ROM bits 18..19
                if (flags.mux)
                    nb = (({15'b0, ram_sel} & 32'h6000) << 5) | ({9'b0, rom_sel} & 32'h33e000);
                else
                    nb = {9'b0, rom_sel};
                upper_bank = nb[22:0] & cfg_rom_mask;
                if (cfg_ram_fitted)
                    ram_out = muxed_ram_bank();
            end
            SEL_ROM_LOCK: begin
                if (!was_mapped) begin
                    nb        = (32'h3c0 | ({24'b0, d} & 32'h3c)) << 14;
                    rom_lock  = nb[23:0];
                    flags.mux = d[6];
                end
                if (!flags.lock)
                    flags.mode = d[0];
                if (cfg_ram_fitted)
                    ram_out = muxed_ram_bank();
            end
            default: ;  // 0x8000 and up: no register
        endcase
    endfunction

    // One accepted access: update the model and return the result beat it causes
    function automatic t_result map_access(logic op, t_addr addr, t_data d);
        t_result res;
        t_rom    bank;
        res = '0;
        if (op == OP_WRITE) begin
            bus_write(addr, d);
        end else if (addr[15] == 1'b0) begin
            if (addr[14] == 1'b0)
                bank = flags.mapped ? (upper_bank & rom_lock[22:0]) : cfg_top_bank;
            else
                bank = flags.mapped ? upper_bank : (cfg_top_bank | 23'h4000);
            res.rom_address    = (bank | {9'b0, addr[13:0]}) & cfg_rom_mask;
            res.rom_read_valid = 1'b1;
        end
        res.ram_bank_offset = ram_out;
        res.ram_enabled     = flags.ramen & cfg_ram_fitted;
        res.is_mapped       = flags.mapped;
        res.bank_mode       = flags.mode;
        return res;
    endfunction

    // Drive one access beat after a random gap; valid is left high for a back-to-back beat
    task automatic send_access(logic op, t_addr addr, t_data d);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.operation  <= op;
        in_if.address    <= addr;
        in_if.write_data <= d;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        bank_results_q.push_back(map_access(op, addr, d));
    endtask

    // Stop sending and wait until every predicted beat has come back, plus latency
    task automatic drain();
        in_if.valid <= 1'b0;
        while (bank_results_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write then read-back of one config register, only with the mapper idle
    task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
        drain();
        case (idx)
            REG_TOP_BANK: cfg_top_bank   = value[22:0];
            REG_ROM_MASK: cfg_rom_mask   = value[22:0];
            REG_RAM_PRES: cfg_ram_fitted = value[0];
            default: ;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== value)
            report_error($sformatf("register %0d reads %h, wrote %h", idx, prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(t_rom top, t_rom mask, logic ram);
        cfg_write(REG_TOP_BANK, {9'b0, top});
        cfg_write(REG_ROM_MASK, {9'b0, mask});
        cfg_write(REG_RAM_PRES, {31'b0, ram});
    endtask

    // Random access: mostly the register/ROM windows, some above 0x8000.
    // Set-up phases keep the mapping bit clear so the mapper stays unmapped.
    task automatic send_random_access(bit keep_setup);
        logic  op;
        t_addr addr;
        t_data d;
        op   = ($urandom_range(0, 99) < 55) ? OP_WRITE : OP_READ;
        addr = t_addr'($urandom);
        if ($urandom_range(0, 9) != 0)
            addr[15] = 1'b0;
        d = t_data'($urandom);
        if (op == OP_WRITE && addr[15:13] == SEL_RAM_ENABLE) begin
            if ($urandom_range(0, 3) == 0)
                d[3:0] = RAM_ENABLE_KEY;
            if (keep_setup)
                d[6] = 1'b0;
        end
        send_access(op, addr, d);
    endtask

    task automatic run_random_phase(t_rom top, t_rom mask, logic ram, int count,
                                    bit keep_setup);
        set_config(top, mask, ram);
        steady_flow = 1'b1;  // opening stretch with no idling
        for (int i = 0; i < count; i++) begin
            if (i == 20)
                steady_flow = 1'b0;
            send_random_access(keep_setup);
        end
        steady_flow = 1'b0;
    endtask

    // Reset config: top bank 0, full mask, no RAM; ROM reads see the top bank
    task automatic test_reset_reads();
        send_access(OP_READ, 16'h0000, 8'h00);
        send_access(OP_READ, 16'h3fff, 8'hff);
        send_access(OP_READ, 16'h4000, 8'h00);
        send_access(OP_READ, 16'h7fff, 8'hff);
        send_access(OP_READ, 16'hffff, 8'h00);
    endtask

    task automatic test_top_bank_reads();
        set_config(TOP_BANK_MAX, ROM_MASK_ALL, 1'b1);
        send_access(OP_READ, 16'h0000, 8'h00);
        send_access(OP_READ, 16'h7fff, 8'h00);
    endtask

    // Set-up writes to every window, mode lock, multiplex, RAM enable key, ignored high writes
    task automatic test_setup_writes();
        send_access(OP_WRITE, 16'h2000, 8'h00);  // zero low bits -> bank one
        send_access(OP_WRITE, 16'h3fff, 8'hff);
        send_access(OP_WRITE, 16'h4000, 8'h4f);  // RAM bank 15, mode lock on
        send_access(OP_WRITE, 16'h6000, 8'h01);  // mode held by lock
        send_access(OP_WRITE, 16'h5fff, 8'h0f);  // lock off
        send_access(OP_WRITE, 16'h7fff, 8'h7d);  // multiplex on, mode 1
        send_access(OP_WRITE, 16'h0000, 8'h0a);  // RAM enable key
        send_access(OP_WRITE, 16'h1fff, 8'h35);  // RAM off, lock mask bits
        send_access(OP_WRITE, 16'ha000, 8'hff);  // above 0x8000: ignored
        send_access(OP_WRITE, 16'he000, 8'h4a);  // would map, but ignored
    endtask

    task automatic test_setup_random();
        run_random_phase(t_rom'($urandom_range(0, TOP_BANK_MAX)), ROM_MASK_ALL, 1'b1, 100, 1'b1);
        run_random_phase(23'h0, 23'h1fffff, 1'b0, 100, 1'b1);
        run_random_phase(TOP_BANK_MAX, t_rom'($urandom), 1'b1, 100, 1'b1);
    endtask

    // One-way switch to mapped mode, then locked writes and window reads
    task automatic test_map_entry();
        set_config(t_rom'($urandom_range(0, TOP_BANK_MAX)), ROM_MASK_ALL, 1'b1);
        send_access(OP_WRITE, 16'h0000, 8'h4a);  // map and enable RAM
        send_access(OP_READ,  16'h0000, 8'h00);
        send_access(OP_READ,  16'h7fff, 8'h00);
        send_access(OP_WRITE, 16'h2000, 8'h00);  // zero bank after mapping -> bank one
        send_access(OP_WRITE, 16'h2000, 8'hff);
        send_access(OP_WRITE, 16'h4000, 8'h03);
        send_access(OP_WRITE, 16'h6000, 8'h00);
        send_access(OP_READ,  16'h4000, 8'h00);
    endtask

    task automatic test_mapped_random();
        run_random_phase(t_rom'($urandom_range(0, TOP_BANK_MAX)), ROM_MASK_ALL, 1'b1, 110, 1'b0);
        run_random_phase(23'h0, 23'h0fffff, 1'b1, 110, 1'b0);
        run_random_phase(TOP_BANK_MAX, 23'h0, 1'b0, 110, 1'b0);
        run_random_phase(t_rom'($urandom_range(0, TOP_BANK_MAX)), t_rom'($urandom), 1'b1,
                         110, 1'b0);
        run_random_phase(t_rom'($urandom_range(0, TOP_BANK_MAX)), ROM_MASK_ALL, 1'b1, 110, 1'b0);
    endtask

    // Result side: random backpressure, owns out_if.ready
    initial begin
        int stall;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // Each result beat against the oldest prediction; values sampled as of the edge
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (bank_results_q.size() == 0) begin
                report_error("result beat with nothing expected");
            end else begin
                want = bank_results_q.pop_front();
                if (out_if.rom_address !== want.rom_address)
                    report_error($sformatf("rom_address %h, want %h",
                                           out_if.rom_address, want.rom_address));
                if (out_if.rom_read_valid !== want.rom_read_valid)
                    report_error($sformatf("rom_read_valid %b, want %b",
                                           out_if.rom_read_valid, want.rom_read_valid));
                if (out_if.ram_bank_offset !== want.ram_bank_offset)
                    report_error($sformatf("ram_bank_offset %h, want %h",
                                           out_if.ram_bank_offset, want.ram_bank_offset));
                if (out_if.ram_enabled !== want.ram_enabled)
                    report_error($sformatf("ram_enabled %b, want %b",
                                           out_if.ram_enabled, want.ram_enabled));
                if (out_if.is_mapped !== want.is_mapped)
                    report_error($sformatf("is_mapped %b, want %b",
                                           out_if.is_mapped, want.is_mapped));
                if (out_if.bank_mode !== want.bank_mode)
                    report_error($sformatf("bank_mode %b, want %b",
                                           out_if.bank_mode, want.bank_mode));
            end
        end
    end

    initial begin
        i_clk            = 1'b0;
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        in_if.valid      <= 1'b0;
        in_if.operation  <= OP_READ;
        in_if.address    <= '0;
        in_if.write_data <= '0;
        error_count      = 0;
        steady_flow      = 1'b0;
        // model at reset
        cfg_top_bank   = '0;
        cfg_rom_mask   = ROM_MASK_ALL;
        cfg_ram_fitted = 1'b0;
        rom_sel        = '0;
        upper_bank     = 23'h4000;
        ram_sel        = '0;
        ram_out        = '0;
        rom_lock       = '0;
        ram_lock       = '0;
        flags          = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // set-up mode first: mapping is one-way and reset is never repeated
        test_reset_reads();
        test_top_bank_reads();
        test_setup_writes();
        test_setup_random();
        test_map_entry();
        test_mapped_random();

        drain();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
